// ===== hdl/fcsp_pkg.sv =====
`timescale 1ns / 1ps
package fcsp_pkg;
  localparam int MaxSets   = 64;
  localparam int MaxWays   = 8;
  localparam int AddrWidth = 48;
  localparam int SetW      = $clog2(MaxSets);
  localparam int WayW      = $clog2(MaxWays);
  localparam int CntW      = 32;

  localparam logic [1:0] RegBlockBits = 2'd0;
  localparam logic [1:0] RegSetBits   = 2'd1;
  localparam logic [1:0] RegWaysUsed  = 2'd2;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // One classified access handed from the front end to the back end.
  typedef struct packed {
    logic                 is_write;
    logic [AddrWidth-1:0] blk;
    logic [AddrWidth-1:0] next_blk;
    logic [SetW-1:0]      set;
    logic [SetW-1:0]      next_set;
  } acc_t;

  typedef struct packed {
    logic          plain_hit;
    logic          prefetch_hit;
    logic [CntW-1:0] plain_mem_reads;
    logic [CntW-1:0] plain_mem_writes;
    logic [CntW-1:0] plain_hit_count;
    logic [CntW-1:0] plain_miss_count;
    logic [CntW-1:0] pf_mem_reads;
    logic [CntW-1:0] pf_mem_writes;
    logic [CntW-1:0] pf_hit_count;
    logic [CntW-1:0] pf_miss_count;
  } res_t;
endpackage

// ===== hdl/fcsp_if.sv =====
`timescale 1ns / 1ps
interface fcsp_in_if import fcsp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [AddrWidth-1:0] address;
  modport source (output valid, operation, address, input ready);
  modport sink (input valid, operation, address, output ready);
endinterface

interface fcsp_out_if import fcsp_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface fcsp_cfg_if ();
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [3:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// ===== hdl/fifo_cache_sim_with_prefetch.sv =====
`timescale 1ns / 1ps
// Dual cache simulator: every access word on in_s is looked up in a plain
// FIFO set-associative cache and in a second one with next-line prefetch.
// Channels: in_s (operation, address), out_s (hit flags and eight running
// counters), cfg_s (index 0 block_bits, 1 set_bits, 2 ways_used).
// A front end computes block numbers and set indexes and queues up to two
// accesses; the back end reads the addressed set of both caches into
// registers, then compares and fills, then handles the prefetch block and
// registers the result.
// The back end takes no new access until the last result is handed off;
// its sequencer steps are set read, demand lookup, next-block lookup and
// result handoff.
// Reset clears counters and configuration (block_bits 4, set_bits 0,
// ways_used 1) at once; a pass over all 64 sets then clears valid bits and
// fill pointers, during which the queue takes two words and in_s then stalls.
// When out_s stalls the result holds; the queue keeps taking up to two more
// words before in_s ready drops.
// Configuration is always ready and must be written only while idle.
module fifo_cache_sim_with_prefetch import fcsp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  fcsp_in_if.sink    in_s,
  fcsp_out_if.source out_s,
  fcsp_cfg_if.sink   cfg_s
);
  logic [3:0] block_bits_q;
  logic [2:0] set_bits_q;
  logic [3:0] ways_used_q;
  logic q_valid, q_ready;
  acc_t q_data;

  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bits_q <= 4'd4;
      set_bits_q   <= 3'd0;
      ways_used_q  <= 4'd1;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.index)
        RegBlockBits: block_bits_q <= cfg_s.wdata;
        RegSetBits:   set_bits_q   <= cfg_s.wdata[2:0];
        RegWaysUsed:  ways_used_q  <= cfg_s.wdata;
        default: ;
      endcase
    end
  end

  fcsp_front u_front (
    .clk_i, .rst_ni, .in_s,
    .block_bits_i(block_bits_q), .set_bits_i(set_bits_q),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  fcsp_back u_back (
    .clk_i, .rst_ni, .ways_used_i(ways_used_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data), .out_s
  );
endmodule

// ===== hdl/fcsp_front.sv =====
`timescale 1ns / 1ps
module fcsp_front import fcsp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  fcsp_in_if.sink       in_s,
  input  logic [3:0]    block_bits_i,
  input  logic [2:0]    set_bits_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output acc_t          q_data_o
);
  // Two-entry queue toward the back end.
  acc_t       buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  acc_t       acc;
  logic [AddrWidth-1:0] nxt_addr;
  logic [SetW-1:0] smask;
  logic push, pop;

  assign smask    = SetW'((7'd1 << set_bits_i) - 7'd1);
  assign nxt_addr = in_s.address + (AddrWidth'(1) << block_bits_i);

  always_comb begin
    acc.is_write = (in_s.operation == OpWrite);
    acc.blk      = in_s.address >> block_bits_i;
    acc.next_blk = nxt_addr >> block_bits_i;
    acc.set      = acc.blk[SetW-1:0] & smask;
    acc.next_set = acc.next_blk[SetW-1:0] & smask;
  end

  assign in_s.ready = (cnt_q != 2'd2);
  assign push       = in_s.valid && in_s.ready;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_data_o   = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== hdl/fcsp_back.sv =====
`timescale 1ns / 1ps
module fcsp_back import fcsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [3:0]  ways_used_i,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  acc_t        q_data_i,
  fcsp_out_if.source  out_s
);
  typedef enum logic [2:0] {StClear, StIdle, StLook, StNext, StOut} state_e;

  // One set of a cache: fill pointer, valid bits and tags of every way.
  typedef struct packed {
    logic [WayW-1:0]                   fp;
    logic [MaxWays-1:0]                vld;
    logic [MaxWays-1:0][AddrWidth-1:0] tag;
  } row_t;

  // Set memories, one row read per cycle into a register.
  row_t pmem [MaxSets];
  row_t fmem [MaxSets];
  row_t prow_q, frow_q;
  row_t pupd, fupd;
  logic [CntW-1:0] cnt_q [8];
  logic [SetW-1:0] clr_q;

  state_e state_q;
  acc_t   acc_q;
  logic   ph_q, fh_q;
  res_t   res_q;

  logic [WayW:0]   ways;
  logic [MaxWays-1:0] wen;
  logic [AddrWidth-1:0] lk_blk;
  logic            ph, fh;
  logic [WayW-1:0] pslot, fslot, pnext, fnext;

  always_comb begin
    if (ways_used_i == 4'd0) ways = (WayW+1)'(1);
    else if (ways_used_i > 4'(MaxWays)) ways = (WayW+1)'(MaxWays);
    else ways = (WayW+1)'(ways_used_i);
    for (int w = 0; w < MaxWays; w++) wen[w] = ((WayW+1)'(w) < ways);
  end

  // Prefetch lookup uses the demand block first, then the next block.
  assign lk_blk = (state_q == StNext) ? acc_q.next_blk : acc_q.blk;

  // Compare against the registered rows and build the filled rows
  always_comb begin
    ph = 1'b0;
    fh = 1'b0;
    for (int w = 0; w < MaxWays; w++) begin
      if (wen[w] && prow_q.vld[w] && prow_q.tag[w] == acc_q.blk) ph = 1'b1;
      if (wen[w] && frow_q.vld[w] && frow_q.tag[w] == lk_blk) fh = 1'b1;
    end
    pslot = ((WayW+1)'(prow_q.fp) >= ways) ? '0 : prow_q.fp;
    fslot = ((WayW+1)'(frow_q.fp) >= ways) ? '0 : frow_q.fp;
    pnext = ((WayW+1)'(pslot) + 1'b1 == ways) ? '0 : pslot + 1'b1;
    fnext = ((WayW+1)'(fslot) + 1'b1 == ways) ? '0 : fslot + 1'b1;
    pupd = prow_q;
    pupd.tag[pslot] = acc_q.blk;
    pupd.vld[pslot] = 1'b1;
    pupd.fp = pnext;
    fupd = frow_q;
    fupd.tag[fslot] = lk_blk;
    fupd.vld[fslot] = 1'b1;
    fupd.fp = fnext;
  end

  assign q_ready_o   = (state_q == StIdle);
  assign out_s.valid = (state_q == StOut);
  assign out_s.data  = res_q;

  // Memory ports, row registers and result
  always_ff @(posedge clk_i) begin
    case (state_q)
      StClear: begin
        pmem[clr_q] <= '0;
        fmem[clr_q] <= '0;
      end
      StIdle: begin
        if (q_valid_i) begin
          acc_q  <= q_data_i;
          prow_q <= pmem[q_data_i.set];
          frow_q <= fmem[q_data_i.set];
        end
      end
      StLook: begin
        ph_q <= ph;
        fh_q <= fh;
        if (!ph) pmem[acc_q.set] <= pupd;
        if (!fh) fmem[acc_q.set] <= fupd;
        // Next set equal to the demand set sees the row just filled
        frow_q <= (!fh && acc_q.next_set == acc_q.set) ? fupd : fmem[acc_q.next_set];
      end
      StNext: begin
        if (!fh_q && !fh) fmem[acc_q.next_set] <= fupd;
        res_q.plain_hit        <= ph_q;
        res_q.prefetch_hit     <= fh_q;
        res_q.plain_mem_reads  <= cnt_q[0];
        res_q.plain_mem_writes <= cnt_q[1];
        res_q.plain_hit_count  <= cnt_q[2];
        res_q.plain_miss_count <= cnt_q[3];
        res_q.pf_mem_reads     <= cnt_q[4] + CntW'(!fh_q && !fh);
        res_q.pf_mem_writes    <= cnt_q[5];
        res_q.pf_hit_count     <= cnt_q[6];
        res_q.pf_miss_count    <= cnt_q[7];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      for (int k = 0; k < 8; k++) cnt_q[k] <= '0;
    end else begin
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == SetW'(MaxSets - 1)) state_q <= StIdle;
        end
        StIdle: if (q_valid_i) state_q <= StLook;
        StLook: begin
          cnt_q[0] <= cnt_q[0] + CntW'(!ph);
          cnt_q[1] <= cnt_q[1] + CntW'(acc_q.is_write);
          cnt_q[2] <= cnt_q[2] + CntW'(ph);
          cnt_q[3] <= cnt_q[3] + CntW'(!ph);
          cnt_q[4] <= cnt_q[4] + CntW'(!fh);
          cnt_q[5] <= cnt_q[5] + CntW'(acc_q.is_write);
          cnt_q[6] <= cnt_q[6] + CntW'(fh);
          cnt_q[7] <= cnt_q[7] + CntW'(!fh);
          state_q <= StNext;
        end
        StNext: begin
          // Only a demand miss in the prefetch cache, with the following block absent, prefetches that block.
          if (!fh_q && !fh) cnt_q[4] <= cnt_q[4] + 1'b1;
          state_q <= StOut;
        end
        StOut: if (out_s.ready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
